// ===== sv/dtl_pkg.sv =====
package dtl_pkg;

	// Default list depth
	localparam int DTL_MAX_TASKS = 16;
	// Width of the reported record count
	localparam int DTL_COUNT_W = 5;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_SORT   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] task_id;
		logic [31:0] release_tick;
		logic [31:0] deadline;
		logic [31:0] finish_tick;
		logic        is_aperiodic;
	} rec_t;

	// Read address source
	typedef enum logic [2:0] {
		RA_ZERO, RA_I, RA_I_P1, RA_I_P2, RA_I_M2, RA_J, RA_CNT_M1
	} rsel_t;

	// Write operation
	typedef enum logic [2:0] {
		WR_NONE, WR_I_RD, WR_I_A, WR_SWAP, WR_ZERO_IN
	} wop_t;

	typedef enum logic [2:0] {
		I_HOLD, I_ZERO, I_INC, I_DEC, I_CNT, I_JM1
	} iop_t;

	typedef enum logic [1:0] {
		J_HOLD, J_ONE, J_I1, J_INC
	} jop_t;

	typedef enum logic [1:0] {
		A_HOLD, A_RD, A_SWAP
	} aop_t;

	typedef enum logic [1:0] {
		C_HOLD, C_INC, C_DEC
	} cop_t;

	// Result emitted by a final step
	typedef enum logic [2:0] {
		OS_NONE, OS_OK, OS_OK_REC, OS_EMPTY, OS_FULL, OS_NOT_FOUND
	} ost_t;

	// Jump conditions
	typedef enum logic [3:0] {
		CN_NEVER, CN_ALWAYS, CN_CNT_FULL, CN_CNT_ZERO, CN_CNT_LT2, CN_NOT_I_ONE,
		CN_LAST, CN_NOT_LAST2, CN_MATCH, CN_NOT_J_CNT, CN_OUT_BUSY
	} cond_t;

	// Microprogram addresses
	typedef enum logic [4:0] {
		U_IDLE, U_PUSH0, U_PUSH1, U_PUSH2, U_PUSHW, U_POP0, U_POP1, U_REM0,
		U_REM1, U_NOTF, U_SH0, U_SH1, U_REMD, U_OUTREC, U_SRT0, U_SRT1,
		U_SRT2, U_SRT3, U_SRT4, U_DONE, U_EMPTY, U_FULL
	} upc_t;

	typedef struct packed {
		rsel_t rsel;
		wop_t  wop;
		iop_t  iop;
		jop_t  jop;
		aop_t  aop;
		cop_t  cop;
		ost_t  ost;
		cond_t c1;
		upc_t  t1;
		cond_t c2;
		upc_t  t2;
	} uword_t;

	// Status seen by the sequencer
	typedef struct packed {
		logic cnt_full;
		logic cnt_zero;
		logic cnt_lt2;
		logic i_one;
		logic last;
		logic last2;
		logic match;
		logic j_eq_cnt;
		logic out_busy;
	} flags_t;

	function automatic upc_t entry_of(mode_t m);
		upc_t e;
		case (m)
			MODE_PUSH:   e = U_PUSH0;
			MODE_POP:    e = U_POP0;
			MODE_REMOVE: e = U_REM0;
			MODE_SORT:   e = U_SRT0;
			default:     e = U_IDLE;
		endcase
		return e;
	endfunction

	// Control store
	function automatic uword_t ucode(upc_t pc);
		uword_t w;
		w = '0;
		case (pc)
			U_IDLE: begin
				w.c1 = CN_ALWAYS; w.t1 = U_IDLE;
			end
			// push: report full if the list is full, else shift the list up one place, then write the front
			U_PUSH0: begin
				w.c1 = CN_CNT_FULL; w.t1 = U_FULL;
			end
			U_PUSH1: begin
				w.rsel = RA_CNT_M1; w.iop = I_CNT;
				w.c1 = CN_CNT_ZERO; w.t1 = U_PUSHW;
			end
			U_PUSH2: begin
				w.wop = WR_I_RD; w.iop = I_DEC; w.rsel = RA_I_M2;
				w.c1 = CN_NOT_I_ONE; w.t1 = U_PUSH2;
			end
			U_PUSHW: begin
				w.wop = WR_ZERO_IN; w.cop = C_INC;
				w.c1 = CN_ALWAYS; w.t1 = U_DONE;
			end
			// pop: take the front record, or report empty if there is none
			U_POP0: begin
				w.rsel = RA_ZERO; w.iop = I_ZERO;
				w.c1 = CN_CNT_ZERO; w.t1 = U_EMPTY;
			end
			U_POP1: begin
				w.aop = A_RD;
				w.c1 = CN_ALWAYS; w.t1 = U_SH0;
			end
			// remove: scan for the id, one record per cycle
			U_REM0: begin
				w.rsel = RA_ZERO; w.jop = J_ONE;
				w.c1 = CN_CNT_ZERO; w.t1 = U_NOTF;
			end
			U_REM1: begin
				w.aop = A_RD; w.iop = I_JM1; w.rsel = RA_J; w.jop = J_INC;
				w.c1 = CN_MATCH; w.t1 = U_SH0;
				w.c2 = CN_NOT_J_CNT; w.t2 = U_REM1;
			end
			U_NOTF: begin
				w.ost = OS_NOT_FOUND;
				w.c1 = CN_OUT_BUSY; w.t1 = U_NOTF;
				w.c2 = CN_ALWAYS; w.t2 = U_IDLE;
			end
			// close the gap behind position i
			U_SH0: begin
				w.rsel = RA_I_P1;
				w.c1 = CN_LAST; w.t1 = U_REMD;
			end
			U_SH1: begin
				w.wop = WR_I_RD; w.iop = I_INC; w.rsel = RA_I_P2;
				w.c1 = CN_NOT_LAST2; w.t1 = U_SH1;
			end
			U_REMD: begin
				w.cop = C_DEC;
			end
			U_OUTREC: begin
				w.ost = OS_OK_REC;
				w.c1 = CN_OUT_BUSY; w.t1 = U_OUTREC;
				w.c2 = CN_ALWAYS; w.t2 = U_IDLE;
			end
			// sort: hold position i in A, compare against each later record
			U_SRT0: begin
				w.iop = I_ZERO;
				w.c1 = CN_CNT_LT2; w.t1 = U_DONE;
			end
			U_SRT1: begin
				w.rsel = RA_I; w.jop = J_I1;
			end
			U_SRT2: begin
				w.aop = A_RD; w.rsel = RA_J; w.jop = J_INC;
			end
			U_SRT3: begin
				w.wop = WR_SWAP; w.aop = A_SWAP; w.rsel = RA_J; w.jop = J_INC;
				w.c1 = CN_NOT_J_CNT; w.t1 = U_SRT3;
			end
			U_SRT4: begin
				w.wop = WR_I_A; w.iop = I_INC;
				w.c1 = CN_NOT_LAST2; w.t1 = U_SRT1;
			end
			U_DONE: begin
				w.ost = OS_OK;
				w.c1 = CN_OUT_BUSY; w.t1 = U_DONE;
				w.c2 = CN_ALWAYS; w.t2 = U_IDLE;
			end
			U_EMPTY: begin
				w.ost = OS_EMPTY;
				w.c1 = CN_OUT_BUSY; w.t1 = U_EMPTY;
				w.c2 = CN_ALWAYS; w.t2 = U_IDLE;
			end
			U_FULL: begin
				w.ost = OS_FULL;
				w.c1 = CN_OUT_BUSY; w.t1 = U_FULL;
				w.c2 = CN_ALWAYS; w.t2 = U_IDLE;
			end
			default: begin
				w.c1 = CN_ALWAYS; w.t1 = U_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== sv/dtl_in_if.sv =====
interface dtl_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] task_id;
	logic [31:0] release_tick;
	logic [31:0] deadline;
	logic [31:0] finish_tick;
	logic        is_aperiodic;

	modport source (
		output valid, mode, task_id, release_tick, deadline, finish_tick,
			is_aperiodic,
		input  ready
	);

	modport sink (
		input  valid, mode, task_id, release_tick, deadline, finish_tick,
			is_aperiodic,
		output ready
	);
endinterface

// ===== sv/dtl_out_if.sv =====
interface dtl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] out_task_id;
	logic [31:0] out_release_tick;
	logic [31:0] out_deadline;
	logic [31:0] out_finish_tick;
	logic        out_is_aperiodic;
	logic [4:0]  entry_count;

	modport source (
		output valid, status, out_task_id, out_release_tick, out_deadline,
			out_finish_tick, out_is_aperiodic, entry_count,
		input  ready
	);

	modport sink (
		input  valid, status, out_task_id, out_release_tick, out_deadline,
			out_finish_tick, out_is_aperiodic, entry_count,
		output ready
	);
endinterface

// ===== sv/dtl_seq.sv =====
module dtl_seq import dtl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  mode_t  mode,
	input  flags_t flags,
	output uword_t uw,
	output logic   idle
);

	upc_t pc_q;
	upc_t pc_d;

	function automatic logic cond_true(cond_t c, flags_t f);
		logic r;
		case (c)
			CN_NEVER:     r = 1'b0;
			CN_ALWAYS:    r = 1'b1;
			CN_CNT_FULL:  r = f.cnt_full;
			CN_CNT_ZERO:  r = f.cnt_zero;
			CN_CNT_LT2:   r = f.cnt_lt2;
			CN_NOT_I_ONE: r = !f.i_one;
			CN_LAST:      r = f.last;
			CN_NOT_LAST2: r = !f.last2;
			CN_MATCH:     r = f.match;
			CN_NOT_J_CNT: r = !f.j_eq_cnt;
			CN_OUT_BUSY:  r = f.out_busy;
			default:      r = 1'b0;
		endcase
		return r;
	endfunction

	// Fetch the control word of the current step
	always_comb begin
		uw   = ucode(pc_q);
		idle = (pc_q == U_IDLE);
	end

	// Dispatch on the mode, take a jump, or advance the step counter
	always_comb begin
		if (pc_q == U_IDLE) begin
			pc_d = start ? entry_of(mode) : U_IDLE;
		end else if (cond_true(uw.c1, flags)) begin
			pc_d = uw.t1;
		end else if (cond_true(uw.c2, flags)) begin
			pc_d = uw.t2;
		end else begin
			pc_d = upc_t'(pc_q + 5'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= U_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ===== sv/deadline_task_list_top.sv =====
// Channel | Dir | Handshake     | Payload
// cmd     | in  | valid / ready | mode, task_id, release_tick, deadline, finish_tick,
//         |     |               | is_aperiodic
// rsp     | out | valid / ready | status, out_task_id, out_release_tick, out_deadline,
//         |     |               | out_finish_tick, out_is_aperiodic, entry_count
//
// One command at a time; push, pop, remove and sort are all bound by the single read port
// of the record memory, one record read per cycle.
// A finished result sits in the output register; the sequencer is back in idle on the
// next cycle and takes the next command there.
// Reset clears the record count and the sequencer; the record memory is not cleared.
// A stalled rsp holds the sequencer in its final step until the slot frees.
module deadline_task_list_top import dtl_pkg::*; #(
	parameter int MAX_TASKS = DTL_MAX_TASKS
) (
	input  logic      clk,
	input  logic      arst_n,
	dtl_in_if.sink    cmd,
	dtl_out_if.source rsp
);

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	// Record memory and its registered read port
	rec_t mem_q [MAX_TASKS];
	rec_t rd_q;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	rec_t          a_q;
	rec_t          in_q;

	logic          rsp_valid_q;
	status_t       status_q;
	rec_t          out_rec_q;
	logic [4:0]    entry_count_q;

	uword_t        uw;
	flags_t        flags;
	logic          idle;
	logic          accept;
	logic          out_busy;
	logic          emit;
	logic          swap;

	logic [CW:0]   i_p1_w;
	logic [CW:0]   i_p2_w;
	logic [CW-1:0] i_m2_w;
	logic [CW-1:0] j_m1_w;
	logic [CW-1:0] cnt_m1_w;

	logic [AW-1:0] ra;
	logic          we;
	logic [AW-1:0] wa;
	rec_t          wd;

	dtl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mode   (mode_t'(cmd.mode)),
		.flags  (flags),
		.uw     (uw),
		.idle   (idle)
	);

	assign cmd.ready = idle;
	assign accept    = cmd.valid && idle;
	assign out_busy  = rsp_valid_q && !rsp.ready;
	assign emit      = (uw.ost != OS_NONE) && !out_busy;

	// Index arithmetic
	assign i_p1_w   = {1'b0, i_q} + (CW+1)'(1);
	assign i_p2_w   = {1'b0, i_q} + (CW+1)'(2);
	assign i_m2_w   = i_q - CW'(2);
	assign j_m1_w   = j_q - CW'(1);
	assign cnt_m1_w = cnt_q - CW'(1);

	assign swap = a_q.deadline > rd_q.deadline;

	// Status for the sequencer
	always_comb begin
		flags.cnt_full = (cnt_q == CW'(MAX_TASKS));
		flags.cnt_zero = (cnt_q == '0);
		flags.cnt_lt2  = (cnt_q < CW'(2));
		flags.i_one    = (i_q == CW'(1));
		flags.last     = (i_p1_w == {1'b0, cnt_q});
		flags.last2    = (i_p2_w == {1'b0, cnt_q});
		flags.match    = (rd_q.task_id == in_q.task_id);
		flags.j_eq_cnt = (j_q == cnt_q);
		flags.out_busy = out_busy;
	end

	// Select the read address
	always_comb begin
		case (uw.rsel)
			RA_ZERO:   ra = '0;
			RA_I:      ra = i_q[AW-1:0];
			RA_I_P1:   ra = i_p1_w[AW-1:0];
			RA_I_P2:   ra = i_p2_w[AW-1:0];
			RA_I_M2:   ra = i_m2_w[AW-1:0];
			RA_J:      ra = j_q[AW-1:0];
			RA_CNT_M1: ra = cnt_m1_w[AW-1:0];
			default:   ra = '0;
		endcase
	end

	// Select the write
	always_comb begin
		we = 1'b0;
		wa = i_q[AW-1:0];
		wd = rd_q;
		case (uw.wop)
			WR_NONE: begin
				we = 1'b0;
			end
			WR_I_RD: begin
				we = 1'b1;
			end
			WR_I_A: begin
				we = 1'b1;
				wd = a_q;
			end
			WR_SWAP: begin
				we = swap;
				wa = j_m1_w[AW-1:0];
				wd = a_q;
			end
			WR_ZERO_IN: begin
				we = 1'b1;
				wa = '0;
				wd = in_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_q <= mem_q[ra];
	end

	// Datapath registers: command capture, indexes, held record
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q.task_id      <= cmd.task_id;
			in_q.release_tick <= cmd.release_tick;
			in_q.deadline     <= cmd.deadline;
			in_q.finish_tick  <= cmd.finish_tick;
			in_q.is_aperiodic <= cmd.is_aperiodic;
		end
		case (uw.iop)
			I_HOLD:  i_q <= i_q;
			I_ZERO:  i_q <= '0;
			I_INC:   i_q <= i_q + CW'(1);
			I_DEC:   i_q <= i_q - CW'(1);
			I_CNT:   i_q <= cnt_q;
			I_JM1:   i_q <= j_m1_w;
			default: i_q <= i_q;
		endcase
		case (uw.jop)
			J_HOLD:  j_q <= j_q;
			J_ONE:   j_q <= CW'(1);
			J_I1:    j_q <= i_p1_w[CW-1:0];
			J_INC:   j_q <= j_q + CW'(1);
			default: j_q <= j_q;
		endcase
		case (uw.aop)
			A_HOLD:  a_q <= a_q;
			A_RD:    a_q <= rd_q;
			A_SWAP:  a_q <= swap ? rd_q : a_q;
			default: a_q <= a_q;
		endcase
	end

	// Record count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (uw.cop)
				C_HOLD:  cnt_q <= cnt_q;
				C_INC:   cnt_q <= cnt_q + CW'(1);
				C_DEC:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Output register: load on a final step, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			entry_count_q <= DTL_COUNT_W'(cnt_q);
			out_rec_q     <= (uw.ost == OS_OK_REC) ? a_q : '0;
			case (uw.ost)
				OS_OK, OS_OK_REC: status_q <= ST_DONE;
				OS_EMPTY:         status_q <= ST_EMPTY;
				OS_FULL:          status_q <= ST_FULL;
				OS_NOT_FOUND:     status_q <= ST_NOT_FOUND;
				default:          status_q <= ST_DONE;
			endcase
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = status_q;
	assign rsp.out_task_id      = out_rec_q.task_id;
	assign rsp.out_release_tick = out_rec_q.release_tick;
	assign rsp.out_deadline     = out_rec_q.deadline;
	assign rsp.out_finish_tick  = out_rec_q.finish_tick;
	assign rsp.out_is_aperiodic = out_rec_q.is_aperiodic;
	assign rsp.entry_count      = entry_count_q;

endmodule

// ===== sv/dtl_chk.sv =====
module dtl_chk import dtl_pkg::*; #(
	parameter int MAX_TASKS = DTL_MAX_TASKS
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [4:0]  rsp_entry_count,
	input logic [31:0] rsp_out_task_id
);

	// One command at a time: ready drops after a transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while another is in progress");

	// A full list reports the full count
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == 5'(MAX_TASKS))
		else $error("full status with a count other than the depth");

	// An empty pop reports no records and no record fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == 5'd0
			&& rsp_out_task_id == 32'd0)
		else $error("empty status with records or record fields");

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable({rsp_status, rsp_entry_count, rsp_out_task_id}))
		else $error("result changed or dropped while stalled");

endmodule

bind deadline_task_list_top dtl_chk #(.MAX_TASKS(MAX_TASKS)) u_dtl_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_count (rsp.entry_count),
	.rsp_out_task_id (rsp.out_task_id)
);
